### rtl/mnad_pkg.sv
// Shared types and constants of the motion / no-motion alert detector.
package mnad_pkg;

	localparam int WindowDepth      = 30;
	localparam int SamplesPerSecond = 100;
	localparam int PosW             = $clog2(WindowDepth);
	localparam int FillW            = $clog2(WindowDepth + 1);

	localparam logic [31:0] LevelStart = 32'h7FFF_FFFF;
	localparam logic [23:0] TickMax    = 24'hFF_FFFF;
	localparam logic [31:0] Ticks10s   = 32'(10 * SamplesPerSecond);
	localparam logic [31:0] Ticks1s    = 32'(1 * SamplesPerSecond);
	localparam logic [31:0] Ticks3s    = 32'(3 * SamplesPerSecond);

	typedef enum logic [2:0] {
		OP_SAMPLE = 3'd0,
		OP_CHECK  = 3'd1,
		OP_REARM_M = 3'd2,
		OP_REARM_N = 3'd3,
		OP_RESTART_N = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		CFG_M_EN    = 3'd0,
		CFG_N_EN    = 3'd1,
		CFG_TH_HIGH = 3'd2,
		CFG_TH_LOW  = 3'd3,
		CFG_M_SETUP = 3'd4,
		CFG_M_ACT   = 3'd5,
		CFG_N_SECS  = 3'd6
	} cfg_idx_t;

	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_MOTION = 2'd1;
	localparam logic [1:0] EV_NOMOT  = 2'd2;

	// Controller commands to the datapath
	typedef struct packed {
		logic load;      // capture input item, write window entry
		logic scan_clr;  // start min/max scan
		logic scan_step; // read one window entry
		logic scan_acc;  // fold registered entry into min/max
		logic finish;    // update level, run alert machines, form result
	} mnad_cmd_t;

	// Datapath status to the controller
	typedef struct packed {
		logic is_sample;
		logic full_before;
		logic scan_last;
	} mnad_sts_t;

endpackage

### rtl/mnad_ctrl.sv
// Sequencing controller: load, window scan, finish, output handshake.
module mnad_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output mnad_pkg::mnad_cmd_t cmd,
	input  mnad_pkg::mnad_sts_t sts
);
	import mnad_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DECIDE, ST_SCAN, ST_DRAIN, ST_FINISH
	} st_t;

	st_t  state_q;
	logic out_valid_q;

	// Take a new request only when the result register is empty or being read
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		unique case (state_q)
			ST_DECIDE: cmd.scan_clr = sts.is_sample && sts.full_before;
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				cmd.scan_acc  = 1'b1;
			end
			ST_DRAIN:  cmd.scan_acc = 1'b1;
			ST_FINISH: cmd.finish = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE:   if (cmd.load) state_q <= ST_DECIDE;
				ST_DECIDE: state_q <= (sts.is_sample && sts.full_before) ? ST_SCAN : ST_FINISH;
				ST_SCAN:   if (sts.scan_last) state_q <= ST_DRAIN;
				ST_DRAIN:  state_q <= ST_FINISH;
				ST_FINISH: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b1;
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/mnad_datapath.sv
// Datapath: magnitude window memory, min/max scan, level, alert machines.
module mnad_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic [2:0]          in_operation,
	input  logic [15:0]         in_x,
	input  logic [15:0]         in_y,
	input  logic [15:0]         in_z,
	input  logic [31:0]         in_now,
	input  mnad_pkg::mnad_cmd_t cmd,
	output mnad_pkg::mnad_sts_t sts,
	output logic [47:0]         res_data
);
	import mnad_pkg::*;

	// config registers
	logic        m_en_q, n_en_q;
	logic [31:0] th_high_q, th_low_q;
	logic [15:0] m_setup_q, m_act_q, n_secs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_en_q    <= 1'b0;
			n_en_q    <= 1'b0;
			th_high_q <= 32'd100000;
			th_low_q  <= 32'd50000;
			m_setup_q <= 16'd10;
			m_act_q   <= 16'd5;
			n_secs_q  <= 16'd60;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_M_EN:    m_en_q    <= cfg_data[0];
				CFG_N_EN:    n_en_q    <= cfg_data[0];
				CFG_TH_HIGH: th_high_q <= cfg_data;
				CFG_TH_LOW:  th_low_q  <= cfg_data;
				CFG_M_SETUP: m_setup_q <= cfg_data[15:0];
				CFG_M_ACT:   m_act_q   <= cfg_data[15:0];
				CFG_N_SECS:  n_secs_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// captured item
	logic [2:0]  op_q;
	logic [31:0] now_q;
	logic [15:0] ax, ay, az;
	logic [31:0] sqx, sqy, sqz;

	// abs of signed 16-bit fits 16 bits unsigned (0x8000 -> 32768)
	assign ax  = in_x[15] ? 16'(-in_x) : in_x;
	assign ay  = in_y[15] ? 16'(-in_y) : in_y;
	assign az  = in_z[15] ? 16'(-in_z) : in_z;
	assign sqx = ax * ax;
	assign sqy = ay * ay;
	assign sqz = az * az;

	// window memory
	logic [31:0]      win_mem [WindowDepth];
	logic [PosW-1:0]  wpos_q, rd_idx_q;
	logic [FillW-1:0] fill_q;
	logic [31:0]      rd_data_q, hi_q, lo_q;
	logic             first_q;
	logic             full_before;

	assign full_before = (fill_q == FillW'(WindowDepth));

	// memory write (at load) and registered read (during scan)
	always_ff @(posedge clk) begin
		if (cmd.load && in_operation == OP_SAMPLE)
			win_mem[wpos_q] <= sqx + sqy + sqz;
		if (cmd.scan_step)
			rd_data_q <= win_mem[rd_idx_q];
		if (cmd.load) begin
			op_q  <= in_operation;
			now_q <= in_now;
		end
	end

	assign sts.is_sample   = (op_q == OP_SAMPLE);
	assign sts.full_before = full_before;
	assign sts.scan_last   = (rd_idx_q == PosW'(WindowDepth - 1));

	// scan index, min/max accumulation
	logic acc_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			acc_valid_q <= 1'b0;
			first_q     <= 1'b1;
			hi_q        <= '0;
			lo_q        <= '0;
		end else begin
			acc_valid_q <= cmd.scan_step;
			if (cmd.scan_clr) begin
				rd_idx_q <= '0;
				first_q  <= 1'b1;
			end else if (cmd.scan_step && !sts.scan_last)
				rd_idx_q <= rd_idx_q + PosW'(1);
			if (cmd.scan_acc && acc_valid_q) begin
				first_q <= 1'b0;
				if (first_q || rd_data_q > hi_q) hi_q <= rd_data_q;
				if (first_q || rd_data_q < lo_q) lo_q <= rd_data_q;
			end
		end
	end

	// alert state
	logic [31:0] level_q, m_since_q, n_since_q;
	logic [2:0]  m_st_q;
	logic [1:0]  n_st_q;
	logic [23:0] m_ticks_q, q_ticks_q, nq_ticks_q, nm_ticks_q;
	logic        latched_q;

	// next-state logic for the finish step
	logic [31:0] lv;
	logic [32:0] lv_sum;
	logic        high, low;
	logic [31:0] level_d, m_since_d, n_since_d;
	logic [2:0]  m_st_d;
	logic [1:0]  n_st_d, ev_d;
	logic [23:0] m_ticks_d, q_ticks_d, nq_ticks_d, nm_ticks_d;
	logic        latched_d;
	logic [23:0] mt_inc, qt_inc, nqt_inc, nmt_inc;
	logic        do_update;

	assign lv_sum  = {1'b0, level_q} + {1'b0, hi_q - lo_q};
	assign mt_inc  = (m_ticks_q == TickMax) ? TickMax : m_ticks_q + 24'd1;
	assign qt_inc  = (q_ticks_q == TickMax) ? TickMax : q_ticks_q + 24'd1;
	assign nqt_inc = (nq_ticks_q == TickMax) ? TickMax : nq_ticks_q + 24'd1;
	assign nmt_inc = (nm_ticks_q == TickMax) ? TickMax : nm_ticks_q + 24'd1;

	always_comb begin
		level_d = level_q; m_since_d = m_since_q; n_since_d = n_since_q;
		m_st_d = m_st_q; n_st_d = n_st_q; ev_d = EV_NONE;
		m_ticks_d = m_ticks_q; q_ticks_d = q_ticks_q;
		nq_ticks_d = nq_ticks_q; nm_ticks_d = nm_ticks_q; latched_d = latched_q;
		do_update = (op_q == OP_SAMPLE) && full_before;
		lv   = do_update ? lv_sum[32:1] : level_q;
		high = lv > th_high_q;
		low  = lv < th_low_q;
		case (op_q)
			OP_SAMPLE: if (do_update) begin
				level_d = lv;
				if (m_en_q) begin
					case (m_st_q)
						3'd1: begin
							q_ticks_d = qt_inc;
							if (high) begin q_ticks_d = '0; m_since_d = now_q; end
						end
						3'd2: if (high) begin m_ticks_d = '0; m_st_d = 3'd3; end
						3'd3: begin
							m_ticks_d = mt_inc;
							if (high) q_ticks_d = '0;
							else if (low) q_ticks_d = qt_inc;
							if ({8'd0, q_ticks_d} >= Ticks10s) m_st_d = 3'd0;
							else if ({8'd0, m_ticks_d} >= 32'(m_act_q) * 32'(SamplesPerSecond)) begin
								m_st_d = 3'd4; ev_d = EV_MOTION;
							end
						end
						3'd4: m_st_d = 3'd0;
						default: begin
							m_ticks_d = '0; q_ticks_d = '0; m_since_d = now_q; m_st_d = 3'd1;
						end
					endcase
				end
				if (n_en_q) begin
					case (n_st_q)
						2'd1: if (high) begin nq_ticks_d = '0; n_since_d = now_q; end
						2'd2: if (high) begin n_st_d = 2'd3; nq_ticks_d = '0; nm_ticks_d = '0; end
						2'd3: begin
							nm_ticks_d = nmt_inc;
							if (high) nq_ticks_d = '0;
							else if (low) nq_ticks_d = nqt_inc;
							if ({8'd0, nq_ticks_d} >= Ticks1s) n_st_d = 2'd2;
							else if ({8'd0, nm_ticks_d} >= Ticks3s) begin
								latched_d = 1'b0; n_st_d = 2'd0;
							end
						end
						default: begin
							nq_ticks_d = '0;
							if (!latched_q) begin n_since_d = now_q; n_st_d = 2'd1; end
							else n_st_d = 2'd2;
						end
					endcase
				end
			end
			OP_CHECK: begin
				if (n_en_q) begin
					if (n_st_q == 2'd1 && (now_q - n_since_q) >= 32'(n_secs_q)) n_st_d = 2'd2;
					else if (n_st_q == 2'd2 && !latched_q) begin
						latched_d = 1'b1; ev_d = EV_NOMOT;
					end
				end
				if (m_en_q && m_st_q == 3'd1 && (now_q - m_since_q) >= 32'(m_setup_q))
					m_st_d = 3'd2;
			end
			OP_REARM_M:   m_st_d = 3'd0;
			OP_REARM_N:   begin n_st_d = 2'd0; latched_d = 1'b0; end
			OP_RESTART_N: n_st_d = 2'd0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= '0; fill_q <= '0; level_q <= LevelStart;
			m_st_q <= '0; n_st_q <= '0; m_ticks_q <= '0; q_ticks_q <= '0;
			nq_ticks_q <= '0; nm_ticks_q <= '0; m_since_q <= '0; n_since_q <= '0;
			latched_q <= 1'b0;
		end else begin
			if (cmd.load && in_operation == OP_SAMPLE)
				wpos_q <= (wpos_q == PosW'(WindowDepth - 1)) ? '0 : wpos_q + PosW'(1);
			if (cmd.finish) begin
				if (op_q == OP_SAMPLE && !full_before) fill_q <= fill_q + FillW'(1);
				level_q <= level_d; m_st_q <= m_st_d; n_st_q <= n_st_d;
				m_ticks_q <= m_ticks_d; q_ticks_q <= q_ticks_d;
				nq_ticks_q <= nq_ticks_d; nm_ticks_q <= nm_ticks_d;
				m_since_q <= m_since_d; n_since_q <= n_since_d;
				latched_q <= latched_d;
			end
		end
	end

	// result from the post-update state, valid during the finish step
	// fields from low bit: event, mphase, nphase, latched, level, full
	logic [2:0] m_phase;
	logic       full_after;
	assign m_phase    = (m_st_d > 3'd4) ? 3'd0 : m_st_d;
	assign full_after = full_before ||
		(op_q == OP_SAMPLE && fill_q == FillW'(WindowDepth - 1));
	assign res_data   = {7'd0, full_after, level_d, latched_d, n_st_d, m_phase, ev_d};

endmodule

### rtl/motion_nomotion_alert_detector_core.sv
// Top level of the motion / no-motion alert detector.
//  channel  | dir | fields
//  s_axis   | in  | tdata: operation[2:0] x[18:3] y[34:19] z[50:35] now[82:51]
//  m_axis   | out | tdata: event[1:0] mphase[4:2] nphase[6:5] active[7] level[39:8] full[40]
//  cfg      | in  | cfg_we, cfg_index, cfg_data
// A sample with a full window passes from accept through decide, a 30-entry scan
// with one memory read a cycle, drain and finish back to idle; other requests
// go from decide straight to finish. One request is in work at a time.
// A new request enters only when the result register is empty or being read.
// Reset clears control, level and alert state; the window memory is not cleared.
module motion_nomotion_alert_detector_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [87:0] s_axis_tdata,  // operation, accel_x, accel_y, accel_z, now_seconds
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // alert_event, motion_phase, nomotion_phase, active, level, full
);
	import mnad_pkg::*;

	mnad_cmd_t   cmd;
	mnad_sts_t   sts;
	logic [47:0] res;

	mnad_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.cmd, .sts
	);

	mnad_datapath u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_operation(s_axis_tdata[2:0]),
		.in_x(s_axis_tdata[18:3]), .in_y(s_axis_tdata[34:19]),
		.in_z(s_axis_tdata[50:35]), .in_now(s_axis_tdata[82:51]),
		.cmd, .sts, .res_data(res)
	);

	logic [47:0] out_q;
	always_ff @(posedge clk) begin
		if (cmd.finish) out_q <= res;
	end
	assign m_axis_tdata = out_q;

	logic unused_pad;
	assign unused_pad = ^s_axis_tdata[87:83];

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.scan_step, cmd.finish}))
		else $error("overlapping controller commands");
	a_no_scan_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !cmd.scan_step)
		else $error("scan while accepting");
	a_result_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> m_axis_tvalid)
		else $error("result not presented");

endmodule

### sim/tb_motion_nomotion_alert_detector_core.sv
// Self-checking testbench for the motion / no-motion alert detector core.
module tb_motion_nomotion_alert_detector_core;
	timeunit 1ns;
	timeprecision 1ps;
	import mnad_pkg::*;

	// last member sits in the lowest bits
	typedef struct packed {
		logic        full;
		logic [31:0] level;
		logic        active;
		logic [1:0]  nphase;
		logic [2:0]  mphase;
		logic [1:0]  ev;
	} alert_status_t;

	// Behavioral copy of the detector; compares results in request order
	class alert_scoreboard;
		bit          m_en, n_en;
		logic [31:0] th_hi, th_lo;
		logic [15:0] m_setup, m_act, n_secs;
		logic [31:0] mag_win [WindowDepth];
		int          wpos, fill;
		logic [31:0] level;
		logic [2:0]  m_state;
		logic [23:0] m_ticks, q_ticks;
		logic [31:0] m_since;
		logic [1:0]  n_state;
		logic [23:0] nq_ticks, nm_ticks;
		logic [31:0] n_since;
		bit          latched;
		alert_status_t pending [$];
		int          errors;

		function new();
			m_en = 0; n_en = 0; th_hi = 100000; th_lo = 50000;
			m_setup = 10; m_act = 5; n_secs = 60;
			wpos = 0; fill = 0; level = LevelStart;
			m_state = 0; m_ticks = 0; q_ticks = 0; m_since = 0;
			n_state = 0; nq_ticks = 0; nm_ticks = 0; n_since = 0;
			latched = 0; errors = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [31:0] val);
			case (idx)
				CFG_M_EN:    m_en = val[0];
				CFG_N_EN:    n_en = val[0];
				CFG_TH_HIGH: th_hi = val;
				CFG_TH_LOW:  th_lo = val;
				CFG_M_SETUP: m_setup = val[15:0];
				CFG_M_ACT:   m_act = val[15:0];
				CFG_N_SECS:  n_secs = val[15:0];
				default: ;
			endcase
		endfunction

		function logic [23:0] bump(logic [23:0] v);
			return (v == TickMax) ? v : v + 1;
		endfunction

		function logic [31:0] square(logic signed [15:0] a);
			logic [16:0] m;
			m = (a < 0) ? 17'(-32'(a)) : 17'(a);
			return 32'(m) * 32'(m);
		endfunction

		function logic [1:0] step_motion(logic [31:0] now);
			bit hi;
			hi = level > th_hi;
			case (m_state)
				3'd1: begin
					q_ticks = bump(q_ticks);
					if (hi) begin
						q_ticks = 0;
						m_since = now;
					end
				end
				3'd2: if (hi) begin
					m_ticks = 0;
					m_state = 3'd3;
				end
				3'd3: begin
					m_ticks = bump(m_ticks);
					if (hi) q_ticks = 0;
					else if (level < th_lo) q_ticks = bump(q_ticks);
					if (32'(q_ticks) >= Ticks10s) m_state = 3'd0;
					else if (32'(m_ticks) >= 32'(m_act) * SamplesPerSecond) begin
						m_state = 3'd4;
						return EV_MOTION;
					end
				end
				3'd4: m_state = 3'd0;
				default: begin
					m_ticks = 0;
					q_ticks = 0;
					m_since = now;
					m_state = 3'd1;
				end
			endcase
			return EV_NONE;
		endfunction

		function void step_nomotion(logic [31:0] now);
			bit hi;
			hi = level > th_hi;
			case (n_state)
				2'd1: if (hi) begin
					nq_ticks = 0;
					n_since = now;
				end
				2'd2: if (hi) begin
					n_state = 2'd3;
					nq_ticks = 0;
					nm_ticks = 0;
				end
				2'd3: begin
					nm_ticks = bump(nm_ticks);
					if (hi) nq_ticks = 0;
					else if (level < th_lo) nq_ticks = bump(nq_ticks);
					if (32'(nq_ticks) >= Ticks1s) n_state = 2'd2;
					else if (32'(nm_ticks) >= Ticks3s) begin
						latched = 0;
						n_state = 2'd0;
					end
				end
				default: begin
					nq_ticks = 0;
					if (!latched) begin
						n_since = now;
						n_state = 2'd1;
					end else n_state = 2'd2;
				end
			endcase
		endfunction

		// note an accepted request and queue its expected status
		function void note_request(logic [87:0] d);
			logic [2:0]  op;
			logic [31:0] now, mg, mx, mn;
			logic [32:0] sum;
			logic [1:0]  ev;
			alert_status_t r;
			op = d[2:0];
			now = d[82:51];
			ev = EV_NONE;
			case (op)
				OP_SAMPLE: begin
					mg = square(d[18:3]) + square(d[34:19]) + square(d[50:35]);
					mag_win[wpos] = mg;
					wpos = (wpos + 1 >= WindowDepth) ? 0 : wpos + 1;
					if (fill < WindowDepth) fill++;
					else begin
						mx = mag_win[0];
						mn = mag_win[0];
						for (int i = 1; i < WindowDepth; i++) begin
							if (mag_win[i] > mx) mx = mag_win[i];
							if (mag_win[i] < mn) mn = mag_win[i];
						end
						sum = 33'(level) + 33'(mx - mn);
						level = sum[32:1];
						if (m_en) ev = step_motion(now);
						if (n_en) step_nomotion(now);
					end
				end
				OP_CHECK: begin
					if (n_en) begin
						if (n_state == 2'd1 && (now - n_since) >= 32'(n_secs))
							n_state = 2'd2;
						else if (n_state == 2'd2 && !latched) begin
							latched = 1;
							ev = EV_NOMOT;
						end
					end
					if (m_en && m_state == 3'd1 && (now - m_since) >= 32'(m_setup))
						m_state = 3'd2;
				end
				OP_REARM_M: m_state = 3'd0;
				OP_REARM_N: begin
					n_state = 2'd0;
					latched = 0;
				end
				OP_RESTART_N: n_state = 2'd0;
				default: ;
			endcase
			r.ev = ev;
			r.mphase = (m_state <= 3'd4) ? m_state : 3'd0;
			r.nphase = n_state;
			r.active = latched;
			r.level = level;
			r.full = fill >= WindowDepth;
			pending.push_back(r);
		endfunction

		// compare one accepted result with the oldest expectation
		function void check_status(logic [47:0] d);
			alert_status_t e, a;
			a = d[40:0];
			if (d[47:41] != 0) a = 'x;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", d);
				return;
			end
			e = pending.pop_front();
			if (a.ev !== e.ev || a.mphase !== e.mphase || a.nphase !== e.nphase ||
			    a.active !== e.active || a.level !== e.level || a.full !== e.full ||
			    d[47:41] !== 0) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected ev=%0d mp=%0d np=%0d act=%0d lvl=%h full=%0d, got %h",
						e.ev, e.mphase, e.nphase, e.active, e.level, e.full, d);
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        s_axis_tvalid, s_axis_tready;
	logic [87:0] s_axis_tdata;
	logic        m_axis_tvalid, m_axis_tready;
	logic [47:0] m_axis_tdata;

	motion_nomotion_alert_detector_core uut (.*);

	alert_scoreboard sb;
	logic [31:0] clock_secs;
	bit          hold_off;
	int          idle_cycles;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// result side: a random wait before each result, one long hold-off on request
	initial begin
		int wait_n;
		m_axis_tready = 0;
		wait_n = $urandom_range(0, 16);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_status(m_axis_tdata);
				wait_n = $urandom_range(0, 16);
			end
			if (hold_off || wait_n > 0) begin
				m_axis_tready <= 0;
				if (!hold_off) wait_n--;
			end else m_axis_tready <= 1;
		end
	end

	// watchdog on cycles with no transfer
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else if (++idle_cycles > 5000) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// write enable stays high until the caller drops it after the last write
	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	// send one request, with a random gap first unless told otherwise
	task automatic send(op_t op, logic [15:0] x, logic [15:0] y, logic [15:0] z,
	                    logic [31:0] now, bit gaps);
		int gap;
		gap = gaps ? (($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {5'd0, now, z, y, x, op};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request({5'd0, now, z, y, x, op});
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// sample whose x and most z values are widely spread or nearly constant; y is random
	task automatic sample(bit moving, bit gaps);
		logic [15:0] v;
		v = moving ? 16'($urandom_range(0, 1) ? $urandom_range(0, 200)
		                                      : $urandom_range(20000, 32767))
		           : 16'(1000 + $urandom_range(0, 3));
		if (moving && $urandom_range(0, 1)) v = -v;
		send(OP_SAMPLE, v, 16'($urandom), 16'($urandom_range(0, 2) == 0 ? 0 : v),
			clock_secs, gaps);
	endtask

	task automatic random_request(bit gaps);
		int k;
		k = $urandom_range(0, 99);
		if (k < 3) send(op_t'($urandom_range(5, 7)), 16'($urandom), 16'($urandom),
			16'($urandom), $urandom, gaps);
		else if (k < 6) send(op_t'($urandom_range(2, 4)), 16'($urandom), 16'($urandom),
			16'($urandom), clock_secs, gaps);
		else if (k < 20) begin
			clock_secs += $urandom_range(0, 40);
			send(OP_CHECK, 0, 0, 0, ($urandom_range(0, 30) == 0) ? $urandom : clock_secs,
				gaps);
		end else if (k < 24)
			send(OP_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom), clock_secs, gaps);
		else sample(k < 60, gaps);
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_M_EN;
		cfg_data = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		hold_off = 0;
		clock_secs = 32'hFFFF_FF00;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: field extremes, every operation, partial window fill, wrap of time
		send(OP_CHECK, 0, 0, 0, 0, 0);
		send(OP_REARM_M, 0, 0, 0, 0, 0);
		send(OP_REARM_N, 0, 0, 0, 0, 0);
		send(OP_RESTART_N, 0, 0, 0, 32'hFFFF_FFFF, 0);
		send(op_t'(3'd7), 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
		send(op_t'(3'd5), 0, 0, 0, 0, 0);
		send(OP_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 32'hFFFF_FFFF, 0);
		send(OP_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0);
		send(OP_SAMPLE, 16'hFFFF, 16'h0001, 16'h0000, 0, 0);
		for (int i = 0; i < 14; i++) sample(i[0], 0);
		drain();

		// phases with differing settings, extremes included
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(CFG_M_EN, (ph == 7) ? 32'hFFFF_FFFE : ((ph % 4) != 3));
			write_reg(CFG_N_EN, (ph % 3) != 2);
			case (ph)
				0: begin
					write_reg(CFG_TH_HIGH, 100000);
					write_reg(CFG_TH_LOW, 50000);
				end
				1: begin
					write_reg(CFG_TH_HIGH, 0);
					write_reg(CFG_TH_LOW, 32'hFFFF_FFFF);
				end
				2: begin
					write_reg(CFG_TH_HIGH, 32'hFFFF_FFFF);
					write_reg(CFG_TH_LOW, 0);
				end
				default: begin
					write_reg(CFG_TH_HIGH, $urandom_range(1000000, 200000000));
					write_reg(CFG_TH_LOW, $urandom_range(0, 1000000));
				end
			endcase
			write_reg(CFG_M_SETUP, (ph == 2) ? 16'hFFFF : (ph == 1) ? 0 : $urandom_range(0, 30));
			write_reg(CFG_M_ACT, (ph == 3) ? 16'hFFFF : (ph == 1) ? 0 : $urandom_range(0, 2));
			write_reg(CFG_N_SECS, (ph == 4) ? 16'hFFFF : (ph == 1) ? 0 : $urandom_range(0, 60));
			cfg_we <= 0;
			if (ph == 5) begin
				// long receiver stall while requests keep coming
				fork
					begin
						hold_off = 1;
						repeat (400) @(posedge clk);
						hold_off = 0;
					end
					for (int i = 0; i < 20; i++) random_request(0);
				join
			end
			for (int i = 0; i < 200; i++) random_request(i > 60);
			drain();
		end

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end
endmodule

### files.f
rtl/mnad_pkg.sv
rtl/mnad_ctrl.sv
rtl/mnad_datapath.sv
rtl/motion_nomotion_alert_detector_core.sv
sim/tb_motion_nomotion_alert_detector_core.sv
